// ----- rtl/ratacc_pkg.sv -----
// Shared types and constants for the rational accumulator.
package ratacc_pkg;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned IW = 32;
  localparam int unsigned MW = 66;
  localparam int unsigned MAGW = 65;
  localparam int unsigned GCW = $clog2(MAGW + 1);

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic prep;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } ratacc_cmd_t;

  typedef struct packed {
    logic skip;
    logic no_change;
    logic gcd_done;
    logic div_done;
  } ratacc_sts_t;
endpackage

// ----- rtl/ratacc_if.sv -----
// Valid/ready channel interfaces for the rational accumulator.
interface ratacc_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [31:0] operand_numerator;
  logic signed [31:0] operand_denominator;
  modport source (output valid, operation, operand_numerator, operand_denominator,
                  input ready);
  modport sink   (input valid, operation, operand_numerator, operand_denominator,
                  output ready);
endinterface

interface ratacc_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [31:0] value_numerator;
  logic [30:0]        value_denominator;
  logic [1:0]         status;
  modport source (output valid, value_numerator, value_denominator, status,
                  input ready);
  modport sink   (input valid, value_numerator, value_denominator, status,
                  output ready);
endinterface

// ----- rtl/ratacc_datapath.sv -----
// Datapath: 32x32 products, binary gcd, and restoring division by the gcd.
module ratacc_datapath (
  input  logic                     clk,
  input  ratacc_pkg::ratacc_cmd_t  cmd,
  output ratacc_pkg::ratacc_sts_t  sts,
  input  logic [2:0]               op_in,
  input  logic signed [31:0]       a_in,
  input  logic signed [31:0]       b_in,
  output logic signed [31:0]       num_o,
  output logic [30:0]              den_o,
  output logic [1:0]               status_o,
  input  logic                     rst_n
);
  import ratacc_pkg::*;

  logic [2:0]          op_r;
  logic signed [31:0]  a_r, b_r;
  logic signed [31:0]  kn_r;
  logic [30:0]         kd_r;
  logic signed [63:0]  p1_r, p2_r;
  logic signed [MW-1:0] n_r, d_r;
  logic                neg_r;
  logic [MAGW-1:0]     un_r, ud_r;
  logic [MAGW-1:0]     ga_r, gb_r;
  logic [GCW-1:0]      sh_r;
  logic [MAGW-1:0]     g_r;
  logic [MAGW-1:0]     qn_r, qd_r, rn_r, rd_r;
  logic [GCW-1:0]      cnt_r;
  logic [1:0]          status_r;

  logic signed [31:0]  m1a, m1b, m2a, m2b;
  logic signed [63:0]  prod_a, prod_b;
  logic [MAGW-1:0]     gdiff;
  logic [MAGW:0]       tn, td;
  logic [MAGW-1:0]     lim, fn, fd;
  logic                ovf;

  assign lim = MAGW'((65'd1 << (WIDTH - 1)) - 65'd1);

  always_comb begin
    m1a = kn_r; m1b = b_r; m2a = $signed({1'b0, kd_r}); m2b = a_r;
    case (op_e'(op_r))
      OP_MUL: begin m1b = a_r; m2b = b_r; end
      OP_DIV: begin m1b = b_r; m2b = a_r; end
      default: begin m1b = b_r; m2b = a_r; end
    endcase
    if (cmd.mul2) m2b = b_r;
  end
  assign prod_a = m1a * m1b;
  assign prod_b = m2a * m2b;

  assign sts.skip = (b_r == '0) || (op_r == OP_DIV && a_r == '0);
  assign sts.no_change = op_r > OP_DIV;
  assign sts.gcd_done = (gb_r == '0);
  assign sts.div_done = (cnt_r == '0);

  assign gdiff = (ga_r > gb_r) ? ga_r - gb_r : gb_r - ga_r;
  assign tn = {rn_r, qn_r[MAGW-1]} - {1'b0, g_r};
  assign td = {rd_r, qd_r[MAGW-1]} - {1'b0, g_r};

  always_comb begin
    fn = qn_r; fd = qd_r;
    if (fn == '0) fd = MAGW'(1);
    ovf = (fd > lim) || ((neg_r && fn != '0) ? (fn > lim + MAGW'(1)) : (fn > lim));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kn_r <= 32'sd1;
      kd_r <= 31'd1;
      status_r <= ST_APPLIED;
    end else begin
      if (cmd.load) begin
        op_r <= op_in; a_r <= a_in; b_r <= b_in;
      end
      if (cmd.mul1) begin
        p1_r <= prod_a; p2_r <= prod_b;
        status_r <= sts.skip ? ST_IGNORED : ST_APPLIED;
      end
      if (cmd.mul2) begin
        case (op_e'(op_r))
          OP_LOAD: begin n_r <= MW'(a_r); d_r <= MW'(b_r); end
          OP_ADD:  begin n_r <= MW'(p1_r) + MW'(p2_r); d_r <= MW'(prod_b); end
          OP_SUB:  begin n_r <= MW'(p1_r) - MW'(p2_r); d_r <= MW'(prod_b); end
          OP_MUL:  begin n_r <= MW'(p1_r); d_r <= MW'(p2_r); end
          OP_DIV:  begin n_r <= MW'(p1_r); d_r <= MW'(p2_r); end
          default: begin n_r <= '0; d_r <= MW'(1); end
        endcase
      end
      if (cmd.prep) begin
        neg_r <= n_r[MW-1] ^ d_r[MW-1];
        un_r <= n_r[MW-1] ? MAGW'(-n_r) : MAGW'(n_r);
        ud_r <= d_r[MW-1] ? MAGW'(-d_r) : MAGW'(d_r);
        ga_r <= n_r[MW-1] ? MAGW'(-n_r) : MAGW'(n_r);
        gb_r <= d_r[MW-1] ? MAGW'(-d_r) : MAGW'(d_r);
        sh_r <= '0;
      end
      if (cmd.gcd_step) begin
        if (ga_r == '0) begin
          ga_r <= gb_r; gb_r <= '0;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1; gb_r <= gb_r >> 1; sh_r <= sh_r + GCW'(1);
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else begin
          ga_r <= (ga_r < gb_r) ? ga_r : gb_r;
          gb_r <= gdiff >> 1;
        end
      end
      if (cmd.div_init) begin
        g_r <= (ga_r == '0) ? MAGW'(1) : (ga_r << sh_r);
        qn_r <= un_r; qd_r <= ud_r; rn_r <= '0; rd_r <= '0;
        cnt_r <= GCW'(MAGW);
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r - GCW'(1);
        if (!tn[MAGW]) begin rn_r <= tn[MAGW-1:0]; qn_r <= {qn_r[MAGW-2:0], 1'b1}; end
        else begin rn_r <= {rn_r[MAGW-2:0], qn_r[MAGW-1]}; qn_r <= {qn_r[MAGW-2:0], 1'b0}; end
        if (!td[MAGW]) begin rd_r <= td[MAGW-1:0]; qd_r <= {qd_r[MAGW-2:0], 1'b1}; end
        else begin rd_r <= {rd_r[MAGW-2:0], qd_r[MAGW-1]}; qd_r <= {qd_r[MAGW-2:0], 1'b0}; end
      end
      if (cmd.finish) begin
        if (ovf) begin
          status_r <= ST_OVERFLOW;
        end else begin
          status_r <= ST_APPLIED;
          kd_r <= fd[30:0];
          kn_r <= (neg_r && fn != '0) ? -fn[31:0] : fn[31:0];
        end
      end
    end
  end

  assign num_o = kn_r;
  assign den_o = kd_r;
  assign status_o = status_r;
endmodule

// ----- rtl/ratacc_ctrl.sv -----
// Controller sequencing load, multiply, gcd, divide and result transfer.
module ratacc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ratacc_pkg::ratacc_cmd_t cmd,
  input  ratacc_pkg::ratacc_sts_t sts
);
  import ratacc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_PREP, S_GCD, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.mul1 = (state_r == S_MUL1);
    cmd.mul2 = (state_r == S_MUL2);
    cmd.prep = (state_r == S_PREP);
    cmd.gcd_step = (state_r == S_GCD) && !sts.gcd_done;
    cmd.div_init = (state_r == S_GCD) && sts.gcd_done;
    cmd.div_step = (state_r == S_DIV) && !sts.div_done;
    cmd.finish = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_MUL1;
        S_MUL1: begin
          if (sts.skip || sts.no_change) begin
            state_r <= S_OUT; out_valid_r <= 1'b1;
          end else state_r <= S_MUL2;
        end
        S_MUL2: state_r <= S_PREP;
        S_PREP: state_r <= S_GCD;
        S_GCD:  if (sts.gcd_done) state_r <= S_DIV;
        S_DIV:  if (sts.div_done) state_r <= S_FIN;
        S_FIN:  begin state_r <= S_OUT; out_valid_r <= 1'b1; end
        S_OUT:  if (out_ready) begin state_r <= S_IDLE; out_valid_r <= 1'b0; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

// ----- rtl/rational_accumulator.sv -----
// Rational accumulator top level.
// Keeps a reduced fraction (starts 1/1) and applies load/add/sub/mul/div items
// one at a time, returning one result per item. An item passes through the
// product and sign-handling steps (MUL1, MUL2, PREP), the binary gcd loop, the
// radix-2 divider that splits both parts by the gcd and a commit step; ignored
// items go straight from the first product step to the result. A new item is
// taken only after the result is transferred.
module rational_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  ratacc_in_if.sink   in_ch,
  ratacc_out_if.source out_ch
);
  import ratacc_pkg::*;

  ratacc_cmd_t cmd;
  ratacc_sts_t sts;

  ratacc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  ratacc_datapath u_dp (
    .clk, .cmd, .sts, .rst_n,
    .op_in(in_ch.operation), .a_in(in_ch.operand_numerator),
    .b_in(in_ch.operand_denominator),
    .num_o(out_ch.value_numerator), .den_o(out_ch.value_denominator),
    .status_o(out_ch.status)
  );
endmodule

// ----- rtl/ratacc_checker.sv -----
// Port-level checker for the rational accumulator, bound to the top level.
module ratacc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] den,
  input logic [1:0]  status
);
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> den != 31'd0) else $error("zero denominator");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(den)) else $error("result dropped");
endmodule

bind rational_accumulator ratacc_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .den(out_ch.value_denominator), .status(out_ch.status)
);
